[design/page_frame_manager_lru_assert.svh]
// assertion macros for the page frame manager
`ifndef PAGE_FRAME_MANAGER_LRU_ASSERT_SVH
`define PAGE_FRAME_MANAGER_LRU_ASSERT_SVH

// condition must hold at every edge out of reset
`define PFM_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PFM_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/pfm_pkg.sv]
// shared constants and types for the page frame manager
package pfm_pkg;

    localparam int FRAMES  = 16;
    localparam int FW      = $clog2(FRAMES);
    localparam int CW      = $clog2(FRAMES + 1);
    localparam int PAGE_W  = 31;
    localparam int PIN_W   = 16;
    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    localparam logic [2:0] CMD_FETCH    = 3'd0;
    localparam logic [2:0] CMD_NEW      = 3'd1;
    localparam logic [2:0] CMD_UNPIN    = 3'd2;
    localparam logic [2:0] CMD_FLUSH    = 3'd3;
    localparam logic [2:0] CMD_FLUSHALL = 3'd4;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_PLACED    = 3'd1;
    localparam logic [2:0] ST_ALLPINNED = 3'd2;
    localparam logic [2:0] ST_NOTRES    = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PIN_W-1:0]  pins;
        logic [FW-1:0]     pos;
    } t_entry;

    typedef struct packed {
        logic          we;
        logic [FW-1:0] addr;
        t_entry        data;
    } t_wreq;

endpackage

[design/pfm_ram.sv]
// frame metadata memory, one write and one registered read port
module pfm_ram (
    input  logic            i_clk,
    input  pfm_pkg::t_wreq  i_wreq,
    input  logic            i_re,
    input  logic [pfm_pkg::FW-1:0] i_raddr,
    output pfm_pkg::t_entry o_rdata
);

    pfm_pkg::t_entry r_mem [pfm_pkg::FRAMES];
    pfm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wreq.we) begin
            r_mem[i_wreq.addr] <= i_wreq.data;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/page_frame_manager_lru.sv]
// page frame manager: lookup, lru replacement and flush sequencer
// A request is taken when o_s_tready is high, which it is only while the block is idle. Fetch,
// new, unpin and flush scan all frame entries in the metadata memory, one read a cycle, then
// decide in S_DEC and register their result in S_FIN, after which the block is idle again;
// when a frame in the lru order leaves it, a second pass (S_SWP) between the two renumbers the
// remaining lru positions. Flush-all steps through the frames up to the last dirty one, reads
// each dirty frame's entry and emits one result per dirty frame in frame order, or a single
// done result when no frame is dirty. A finished result waits in the output register and a
// stalled output holds the block before it emits the next one.
module page_frame_manager_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // page_id[30:0], mark_dirty[31]
    input  logic [2:0]  i_s_tuser,   // command[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // frame[3:0], load_page[4], write_back[5], write_page[36:6]
    output logic [2:0]  o_m_tuser,   // status[2:0]
    output logic        o_m_tlast
);

`include "page_frame_manager_lru_assert.svh"

    localparam int FR = pfm_pkg::FRAMES;
    localparam int FW = pfm_pkg::FW;
    localparam int CW = pfm_pkg::CW;
    localparam int PW = pfm_pkg::PAGE_W;
    localparam int NW = pfm_pkg::PIN_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DEC    = 3'd2;
    localparam logic [2:0] S_SWP    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_FA_RD  = 3'd5;
    localparam logic [2:0] S_FA_OUT = 3'd6;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_HIT   = 3'd1;
    localparam logic [2:0] K_PU    = 3'd2;
    localparam logic [2:0] K_PE    = 3'd3;
    localparam logic [2:0] K_UNPIN = 3'd4;
    localparam logic [2:0] K_FLUSH = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [FR-1:0] r_res, n_res, r_dirty, n_dirty, r_inlru, n_inlru;
    logic [CW-1:0] r_unused, n_unused, r_len, n_len, r_i, n_i;
    logic          r_pv, n_pv;
    logic [FW-1:0] r_pa, n_pa;
    logic [2:0]    r_cmd, n_cmd;
    logic [PW-1:0] r_pid, n_pid;
    logic          r_md, n_md;
    logic          r_hv, n_hv, r_ov_old, n_ov_old;
    logic [FW-1:0] r_hf, n_hf, r_of, n_of, r_hpos, n_hpos, r_p, n_p, r_lastf, n_lastf;
    logic [NW-1:0] r_hpins, n_hpins;
    logic [PW-1:0] r_hpage, n_hpage, r_opage, n_opage;
    logic [2:0]    r_kind, n_kind, r_st, n_st;
    logic [FW-1:0] r_fr, n_fr;
    logic          r_ld, n_ld, r_wb, n_wb;
    logic [PW-1:0] r_wp, n_wp;
    logic          r_ov, n_ov;
    logic [2:0]    r_ost, n_ost;
    logic [FW-1:0] r_ofr, n_ofr;
    logic          r_old, n_old, r_owb, n_owb, r_olast, n_olast;
    logic [PW-1:0] r_owp, n_owp;

    pfm_pkg::t_wreq  wreq;
    pfm_pkg::t_entry rd;
    logic            re;
    logic [FW-1:0]   raddr;
    logic            slot;
    logic [FR-1:0]   dmask;
    logic            any_d;
    logic [FW-1:0]   hi_d;
    logic [NW-1:0]   upins;
    logic            joins;

    pfm_ram u_ram (
        .i_clk  (i_clk),
        .i_wreq (wreq),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rd)
    );

    assign slot  = !r_ov || i_m_tready;
    assign dmask = r_res & r_dirty;
    assign upins = (r_hpins != '0) ? r_hpins - 1'b1 : r_hpins;
    assign joins = (upins == '0) && !r_inlru[r_hf] && (r_len < CW'(FR));

    always_comb begin
        any_d = 1'b0;
        hi_d  = '0;
        for (int k = 0; k < FR; k++) begin
            if (dmask[k]) begin
                any_d = 1'b1;
                hi_d  = FW'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state; n_res = r_res; n_dirty = r_dirty; n_inlru = r_inlru;
        n_unused = r_unused; n_len = r_len; n_i = r_i; n_pv = r_pv; n_pa = r_pa;
        n_cmd = r_cmd; n_pid = r_pid; n_md = r_md;
        n_hv = r_hv; n_hf = r_hf; n_hpos = r_hpos; n_hpins = r_hpins; n_hpage = r_hpage;
        n_ov_old = r_ov_old; n_of = r_of; n_opage = r_opage; n_p = r_p; n_lastf = r_lastf;
        n_kind = r_kind; n_st = r_st; n_fr = r_fr; n_ld = r_ld; n_wb = r_wb; n_wp = r_wp;
        n_ov = r_ov && !i_m_tready;
        n_ost = r_ost; n_ofr = r_ofr; n_old = r_old; n_owb = r_owb; n_owp = r_owp;
        n_olast = r_olast;
        wreq = '0;
        re = 1'b0;
        raddr = r_i[FW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd = i_s_tuser;
                    n_pid = i_s_tdata[PW-1:0];
                    n_md  = i_s_tdata[31];
                    n_i   = '0;
                    n_pv  = 1'b0;
                    n_hv  = 1'b0;
                    n_ov_old = 1'b0;
                    n_st = pfm_pkg::ST_DONE; n_fr = '0; n_ld = 1'b0; n_wb = 1'b0; n_wp = '0;
                    n_kind = K_NONE;
                    if (i_s_tuser inside {pfm_pkg::CMD_FETCH, pfm_pkg::CMD_NEW,
                                          pfm_pkg::CMD_UNPIN, pfm_pkg::CMD_FLUSH}) begin
                        n_state = S_SCAN;
                    end else if (i_s_tuser == pfm_pkg::CMD_FLUSHALL) begin
                        n_lastf = hi_d;
                        n_state = any_d ? S_FA_RD : S_FIN;
                    end
                end
            end
            S_SCAN, S_SWP: begin
                if (r_i != CW'(FR)) begin
                    re = 1'b1;
                    n_i = r_i + 1'b1;
                    n_pv = 1'b1;
                    n_pa = r_i[FW-1:0];
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        if (r_state == S_SCAN) begin
                            n_state = S_DEC;
                        end else begin
                            n_len = r_len - 1'b1;
                            n_state = S_FIN;
                        end
                    end
                end
                if (r_pv && r_res[r_pa]) begin
                    if (r_state == S_SCAN) begin
                        if (!r_hv && rd.page == r_pid) begin
                            n_hv = 1'b1; n_hf = r_pa; n_hpos = rd.pos;
                            n_hpins = rd.pins; n_hpage = rd.page;
                        end
                        if (r_inlru[r_pa] && rd.pos == '0) begin
                            n_ov_old = 1'b1; n_of = r_pa; n_opage = rd.page;
                        end
                    end else if (r_inlru[r_pa] && rd.pos > r_p) begin
                        wreq.we = 1'b1;
                        wreq.addr = r_pa;
                        wreq.data = rd;
                        wreq.data.pos = rd.pos - 1'b1;
                    end
                end
            end
            S_DEC: begin
                n_state = S_FIN;
                n_i = '0;
                n_pv = 1'b0;
                case (r_cmd)
                    pfm_pkg::CMD_FETCH, pfm_pkg::CMD_NEW: begin
                        if (r_hv) begin
                            n_kind = K_HIT; n_st = pfm_pkg::ST_HIT; n_fr = r_hf; n_p = r_hpos;
                            if (r_inlru[r_hf]) n_state = S_SWP;
                        end else if (r_unused != '0) begin
                            n_kind = K_PU; n_st = pfm_pkg::ST_PLACED;
                            n_fr = FW'(r_unused - 1'b1);
                            n_ld = (r_cmd == pfm_pkg::CMD_FETCH);
                        end else if (r_len != '0 && r_ov_old) begin
                            n_kind = K_PE; n_st = pfm_pkg::ST_PLACED; n_fr = r_of;
                            n_ld = (r_cmd == pfm_pkg::CMD_FETCH);
                            n_wb = r_dirty[r_of];
                            n_wp = r_dirty[r_of] ? r_opage : '0;
                            n_p = '0;
                            n_state = S_SWP;
                        end else begin
                            n_st = pfm_pkg::ST_ALLPINNED;
                        end
                    end
                    pfm_pkg::CMD_UNPIN: begin
                        if (r_hv) begin
                            n_kind = K_UNPIN; n_fr = r_hf;
                        end else begin
                            n_st = pfm_pkg::ST_NOTRES;
                        end
                    end
                    default: begin
                        if (r_hv) begin
                            n_kind = K_FLUSH; n_fr = r_hf;
                            n_wb = r_dirty[r_hf];
                            n_wp = r_dirty[r_hf] ? r_hpage : '0;
                        end else begin
                            n_st = pfm_pkg::ST_NOTRES;
                        end
                    end
                endcase
            end
            S_FIN: begin
                if (slot) begin
                    n_ov = 1'b1; n_ost = r_st; n_ofr = r_fr; n_old = r_ld; n_owb = r_wb;
                    n_owp = r_wp; n_olast = 1'b1;
                    n_state = S_IDLE;
                    wreq.addr = r_fr;
                    wreq.data.page = r_pid;
                    wreq.data.pins = NW'(1);
                    wreq.data.pos = '0;
                    case (r_kind)
                        K_HIT: begin
                            wreq.we = 1'b1;
                            wreq.data.pins = (r_hpins != pfm_pkg::PIN_MAX) ?
                                             r_hpins + 1'b1 : r_hpins;
                            wreq.data.pos = r_hpos;
                            n_inlru[r_fr] = 1'b0;
                            if (r_cmd == pfm_pkg::CMD_NEW) n_dirty[r_fr] = 1'b1;
                        end
                        K_PU, K_PE: begin
                            wreq.we = 1'b1;
                            n_res[r_fr] = 1'b1;
                            n_inlru[r_fr] = 1'b0;
                            n_dirty[r_fr] = (r_cmd == pfm_pkg::CMD_NEW);
                            if (r_kind == K_PU) n_unused = r_unused - 1'b1;
                        end
                        K_UNPIN: begin
                            wreq.we = 1'b1;
                            wreq.data.page = r_hpage;
                            wreq.data.pins = upins;
                            wreq.data.pos = joins ? r_len[FW-1:0] : r_hpos;
                            if (r_md) n_dirty[r_fr] = 1'b1;
                            if (joins) begin
                                n_inlru[r_fr] = 1'b1;
                                n_len = r_len + 1'b1;
                            end
                        end
                        K_FLUSH: begin
                            n_dirty[r_fr] = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FA_RD: begin
                if (dmask[r_i[FW-1:0]]) begin
                    re = 1'b1;
                    n_state = S_FA_OUT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_FA_OUT: begin
                if (slot) begin
                    n_ov = 1'b1; n_ost = pfm_pkg::ST_DONE; n_ofr = r_i[FW-1:0];
                    n_old = 1'b0; n_owb = 1'b1; n_owp = rd.page;
                    n_olast = (r_i[FW-1:0] == r_lastf);
                    n_dirty[r_i[FW-1:0]] = 1'b0;
                    n_i = r_i + 1'b1;
                    n_state = (r_i[FW-1:0] == r_lastf) ? S_IDLE : S_FA_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res <= '0; r_dirty <= '0; r_inlru <= '0;
            r_unused <= CW'(FR);
            r_len <= '0;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res <= n_res; r_dirty <= n_dirty; r_inlru <= n_inlru;
            r_unused <= n_unused;
            r_len <= n_len;
            r_ov <= n_ov;
            r_pv <= n_pv;
        end
        r_i <= n_i; r_pa <= n_pa; r_cmd <= n_cmd; r_pid <= n_pid; r_md <= n_md;
        r_hv <= n_hv; r_hf <= n_hf; r_hpos <= n_hpos; r_hpins <= n_hpins; r_hpage <= n_hpage;
        r_ov_old <= n_ov_old; r_of <= n_of; r_opage <= n_opage; r_p <= n_p;
        r_lastf <= n_lastf; r_kind <= n_kind; r_st <= n_st; r_fr <= n_fr; r_ld <= n_ld;
        r_wb <= n_wb; r_wp <= n_wp; r_ost <= n_ost; r_ofr <= n_ofr; r_old <= n_old;
        r_owb <= n_owb; r_owp <= n_owp; r_olast <= n_olast;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_owp, r_owb, r_old, r_ofr};
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    `PFM_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= CW'(FR), "lru length beyond pool")
    `PFM_ALWAYS(a_lru_resident, i_clk, i_rst_n, (r_inlru & ~r_res) == '0,
        "lru frame not resident")
    `PFM_ALWAYS(a_frame_count, i_clk, i_rst_n,
        ($countones(r_res) + int'(r_unused)) == FR, "resident and unused frames disagree")
    `PFM_IMPLIES(a_lru_count, i_clk, i_rst_n, r_state == S_IDLE,
        $countones(r_inlru) == int'(r_len), "lru length does not match lru members")

endmodule

[tb/page_frame_manager_lru_checker.sv]
// checker for the page frame manager: frame table prediction and result comparison
module page_frame_manager_lru_checker
    import pfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // page_id[30:0], mark_dirty[31]
    input  logic [2:0]  i_s_tuser,   // command[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // frame[3:0], load_page[4], write_back[5], write_page[36:6]
    input  logic [2:0]  i_m_tuser,   // status[2:0]
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_evict_count,
    output int          o_allpinned_count
);

    typedef struct packed {
        logic [2:0]        status;
        logic [FW-1:0]     frame;
        logic              load_page;
        logic              write_back;
        logic [PAGE_W-1:0] write_page;
        logic              last;
    } t_frame_result;

    logic              resident [FRAMES];
    logic [PAGE_W-1:0] page_of  [FRAMES];
    logic [PIN_W-1:0]  pins     [FRAMES];
    logic              dirty    [FRAMES];
    int                unused_count;
    int                lru_q[$];
    t_frame_result     expected_results[$];

    function automatic int find_frame(input logic [PAGE_W-1:0] pid);
        for (int i = 0; i < FRAMES; i++)
            if (resident[i] && page_of[i] == pid) return i;
        return -1;
    endfunction

    function automatic int lru_index(input int f);
        foreach (lru_q[i])
            if (lru_q[i] == f) return i;
        return -1;
    endfunction

    function automatic void push_result(input logic [2:0] st, input int f, input logic ld,
                                        input logic wb, input logic [PAGE_W-1:0] wp,
                                        input logic lst);
        t_frame_result r;
        r.status     = st;
        r.frame      = FW'(f);
        r.load_page  = ld;
        r.write_back = wb;
        r.write_page = wp;
        r.last       = lst;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_request(input logic [2:0] cmd,
                                            input logic [PAGE_W-1:0] pid, input logic md);
        int f;
        int p;
        int lastf;
        logic wb;
        logic [PAGE_W-1:0] wp;
        case (cmd)
            CMD_FETCH, CMD_NEW: begin
                f = find_frame(pid);
                if (f >= 0) begin
                    p = lru_index(f);
                    if (p >= 0) lru_q.delete(p);
                    if (pins[f] != PIN_MAX) pins[f]++;
                    if (cmd == CMD_NEW) dirty[f] = 1'b1;
                    push_result(ST_HIT, f, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    wb = 1'b0;
                    wp = '0;
                    if (unused_count > 0) begin
                        unused_count--;
                        f = unused_count;
                    end else if (lru_q.size() > 0) begin
                        f = lru_q[0];
                        lru_q.delete(0);
                        wb = dirty[f];
                        if (wb) wp = page_of[f];
                        o_evict_count++;
                    end else begin
                        f = -1;
                    end
                    if (f < 0) begin
                        o_allpinned_count++;
                        push_result(ST_ALLPINNED, 0, 1'b0, 1'b0, '0, 1'b1);
                    end else begin
                        resident[f] = 1'b1;
                        page_of[f]  = pid;
                        pins[f]     = PIN_W'(1);
                        dirty[f]    = (cmd == CMD_NEW);
                        push_result(ST_PLACED, f, cmd != CMD_NEW, wb, wp, 1'b1);
                    end
                end
            end
            CMD_UNPIN: begin
                f = find_frame(pid);
                if (f < 0) begin
                    push_result(ST_NOTRES, 0, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    if (md) dirty[f] = 1'b1;
                    if (pins[f] != 0) pins[f]--;
                    if (pins[f] == 0 && lru_index(f) < 0 && lru_q.size() < FRAMES)
                        lru_q.insert(lru_q.size(), f);
                    push_result(ST_DONE, f, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            CMD_FLUSH: begin
                f = find_frame(pid);
                if (f < 0) begin
                    push_result(ST_NOTRES, 0, 1'b0, 1'b0, '0, 1'b1);
                end else if (dirty[f]) begin
                    dirty[f] = 1'b0;
                    push_result(ST_DONE, f, 1'b0, 1'b1, page_of[f], 1'b1);
                end else begin
                    push_result(ST_DONE, f, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            CMD_FLUSHALL: begin
                lastf = -1;
                for (int i = 0; i < FRAMES; i++)
                    if (resident[i] && dirty[i]) lastf = i;
                if (lastf < 0) push_result(ST_DONE, 0, 1'b0, 1'b0, '0, 1'b1);
                for (int i = 0; i < FRAMES; i++)
                    if (resident[i] && dirty[i]) begin
                        dirty[i] = 1'b0;
                        push_result(ST_DONE, i, 1'b0, 1'b1, page_of[i], i == lastf);
                    end
            end
            default: ;
        endcase
    endfunction

    assign o_pending = expected_results.size();

    initial begin
        o_fail_count      = 0;
        o_result_count    = 0;
        o_evict_count     = 0;
        o_allpinned_count = 0;
        unused_count      = FRAMES;
        for (int i = 0; i < FRAMES; i++) begin
            resident[i] = 1'b0;
            page_of[i]  = '0;
            pins[i]     = '0;
            dirty[i]    = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result exp_r;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                predict_request(i_s_tuser, i_s_tdata[30:0], i_s_tdata[31]);
            if (i_m_tvalid && i_m_tready) begin
                got.status     = i_m_tuser;
                got.frame      = i_m_tdata[3:0];
                got.load_page  = i_m_tdata[4];
                got.write_back = i_m_tdata[5];
                got.write_page = i_m_tdata[36:6];
                got.last       = i_m_tlast;
                o_result_count++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (got !== exp_r || i_m_tdata[39:37] !== 3'b000) begin
                        o_fail_count++;
                        $display("%0t: mismatch expected %p actual %p (pad %b)",
                                 $time, exp_r, got, i_m_tdata[39:37]);
                    end
                end
            end
        end
    end

endmodule

[tb/page_frame_manager_lru_test.sv]
// testbench top: stimulus, output back-pressure and verdict for the page frame manager
module page_frame_manager_lru_test;
    import pfm_pkg::*;

    localparam logic [2:0] CMD_IGNORED = 3'd5;
    localparam int         RANDOM_ITEMS = 440;
    localparam int         CALM_AFTER   = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count, pending, result_count, evict_count, allpinned_count;
    int          sent;

    page_frame_manager_lru u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    page_frame_manager_lru_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .i_m_tlast         (m_tlast),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_result_count    (result_count),
        .o_evict_count     (evict_count),
        .o_allpinned_count (allpinned_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_request(input logic [2:0] cmd, input logic [PAGE_W-1:0] pid,
                                input logic md);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {md, pid};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
        if (sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 9) == 0) return PAGE_W'($urandom);
        if ($urandom_range(0, 23) == 0) return '1;
        return PAGE_W'($urandom_range(0, 22));
    endfunction

    function automatic logic [2:0] pick_command();
        int w;
        w = $urandom_range(0, 99);
        if (w < 30) return CMD_FETCH;
        if (w < 40) return CMD_NEW;
        if (w < 78) return CMD_UNPIN;
        if (w < 88) return CMD_FLUSH;
        if (w < 95) return CMD_FLUSHALL;
        return 3'($urandom_range(5, 7));
    endfunction

    // output side: random stalls, one long hold-off, more random stalls, then always ready
    initial begin
        m_tready <= 1'b0;
        wait (i_rst_n);
        while (sent < 60) begin
            m_tready <= ($urandom_range(0, 2) != 0);
            @(posedge i_clk);
        end
        m_tready <= 1'b0;
        repeat (400) @(posedge i_clk);
        while (sent < CALM_AFTER) begin
            if ($urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        m_tready <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("page_frame_manager_lru regression: fail");
        $finish;
    end

    initial begin
        sent     = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_FETCH;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, fill every frame pinned, then overflow
        send_request(CMD_FLUSHALL, '0, 1'b0);
        send_request(CMD_UNPIN, 31'd5, 1'b1);
        send_request(CMD_FLUSH, 31'd5, 1'b0);
        send_request(CMD_FETCH, '0, 1'b0);
        send_request(CMD_FETCH, '1, 1'b0);
        for (int i = 1; i < 15; i++) send_request(CMD_FETCH, PAGE_W'(i), 1'b0);
        send_request(CMD_NEW, 31'd15, 1'b0);
        send_request(CMD_FETCH, 31'd16, 1'b0);
        send_request(CMD_NEW, '1, 1'b0);
        send_request(CMD_IGNORED, 31'd3, 1'b1);
        send_request(CMD_UNPIN, '1, 1'b1);
        send_request(CMD_UNPIN, '1, 1'b0);
        send_request(CMD_FLUSH, '1, 1'b0);
        send_request(CMD_FLUSHALL, '0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_request(pick_command(), pick_page(), 1'($urandom));
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests and %0d results: %0d evictions, %0d all-pinned refusals",
                 sent, result_count, evict_count, allpinned_count);
        if (fail_count == 0 && pending == 0)
            $display("page_frame_manager_lru regression: pass");
        else
            $display("page_frame_manager_lru regression: fail");
        $finish;
    end

endmodule
